// ===== hdl/triangle_unit_normal_top_assert.svh =====
// Assertion macros for the triangle normal block.
`ifndef TRIANGLE_UNIT_NORMAL_TOP_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_TOP_ASSERT_SVH

// Check outside reset.
`define TUN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every edge, reset included.
`define TUN_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/tun_pkg.sv =====
package tun_pkg;

   localparam int OUT_WIDTH = 16;

   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [2:0] neg;
   } ctl_type;

endpackage

// ===== hdl/tun_if.sv =====
interface tun_req_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] a_z;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic signed [COORD_WIDTH-1:0] b_z;
   logic signed [COORD_WIDTH-1:0] c_x;
   logic signed [COORD_WIDTH-1:0] c_y;
   logic signed [COORD_WIDTH-1:0] c_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 output ready);
endinterface

interface tun_rsp_if ();
   logic                                   valid;
   logic                                   ready;
   logic signed [tun_pkg::OUT_WIDTH-1:0]   normal_x;
   logic signed [tun_pkg::OUT_WIDTH-1:0]   normal_y;
   logic signed [tun_pkg::OUT_WIDTH-1:0]   normal_z;

   modport source (output valid, normal_x, normal_y, normal_z, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

// ===== hdl/tun_cross.sv =====
module tun_cross #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] a [3],
   input  logic signed [COORD_WIDTH-1:0] b [3],
   input  logic signed [COORD_WIDTH-1:0] c [3],
   output logic [4*(COORD_WIDTH+1)-1:0]  sq_out [3],
   output logic [4*(COORD_WIDTH+1)+1:0]  s_out,
   output tun_pkg::ctl_type              ctl_out
);
   localparam int EW = COORD_WIDTH + 1;
   localparam int PW = 2 * EW;
   localparam int NW = PW + 1;
   localparam int MW = PW;
   localparam int H  = (MW + 1) / 2;
   localparam int LW = MW - H;
   localparam int QW = 2 * MW;
   localparam int SW = QW + 2;

   logic [6:0]            v_ff;
   logic signed [EW-1:0]  e1_ff [3];
   logic signed [EW-1:0]  e2_ff [3];
   logic signed [PW-1:0]  p_ff [6];
   logic signed [NW-1:0]  n_ff [3];
   logic [MW-1:0]         mag_ff [3];
   logic [2:0]            neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic                  zero4_ff, zero5_ff, zero6_ff, zero7_ff;
   logic [2*LW-1:0]       hh_ff [3];
   logic [LW+H-1:0]       hl_ff [3];
   logic [2*H-1:0]        ll_ff [3];
   logic [QW-1:0]         sq6_ff [3];
   logic [QW-1:0]         sq7_ff [3];
   logic [SW-1:0]         s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= $signed({a[i][COORD_WIDTH-1], a[i]}) -
                        $signed({b[i][COORD_WIDTH-1], b[i]});
            e2_ff[i] <= $signed({b[i][COORD_WIDTH-1], b[i]}) -
                        $signed({c[i][COORD_WIDTH-1], c[i]});
         end
         p_ff[0] <= e1_ff[1] * e2_ff[2];
         p_ff[1] <= e1_ff[2] * e2_ff[1];
         p_ff[2] <= e1_ff[2] * e2_ff[0];
         p_ff[3] <= e1_ff[0] * e2_ff[2];
         p_ff[4] <= e1_ff[0] * e2_ff[1];
         p_ff[5] <= e1_ff[1] * e2_ff[0];
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= $signed({p_ff[2*i][PW-1], p_ff[2*i]}) -
                       $signed({p_ff[2*i+1][PW-1], p_ff[2*i+1]});
            mag_ff[i] <= n_ff[i][NW-1] ? MW'(-n_ff[i]) : MW'(n_ff[i]);
            neg4_ff[i] <= n_ff[i][NW-1];
            hh_ff[i] <= mag_ff[i][MW-1:H] * mag_ff[i][MW-1:H];
            hl_ff[i] <= mag_ff[i][MW-1:H] * mag_ff[i][H-1:0];
            ll_ff[i] <= mag_ff[i][H-1:0] * mag_ff[i][H-1:0];
            sq6_ff[i] <= (QW'(hh_ff[i]) << (2 * H)) + (QW'(hl_ff[i]) << (H + 1)) +
                         QW'(ll_ff[i]);
            sq7_ff[i] <= sq6_ff[i];
         end
         zero4_ff <= (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
         s_ff <= SW'(sq6_ff[0]) + SW'(sq6_ff[1]) + SW'(sq6_ff[2]);
         neg5_ff  <= neg4_ff;
         neg6_ff  <= neg5_ff;
         neg7_ff  <= neg6_ff;
         zero5_ff <= zero4_ff;
         zero6_ff <= zero5_ff;
         zero7_ff <= zero6_ff;
      end
   end

   assign sq_out        = sq7_ff;
   assign s_out         = s_ff;
   assign ctl_out.valid = v_ff[6];
   assign ctl_out.zero  = zero7_ff;
   assign ctl_out.neg   = neg7_ff;
endmodule

// ===== hdl/tun_div.sv =====
module tun_div #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [4*(COORD_WIDTH+1)-1:0]  sq_in [3],
   input  logic [4*(COORD_WIDTH+1)+1:0]  s_in,
   input  tun_pkg::ctl_type              ctl_in,
   output logic [2*FRAC_BITS+2:0]        d_out [3],
   output tun_pkg::ctl_type              ctl_out
);
   localparam int QW = 4 * (COORD_WIDTH + 1);
   localparam int SW = QW + 2;
   localparam int QB = 2 * FRAC_BITS + 3;

   logic [SW-1:0]    r_ff [QB][3];
   logic [QB-1:0]    d_ff [QB][3];
   logic [SW-1:0]    s_ff [QB];
   tun_pkg::ctl_type c_ff [QB];

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [SW:0]      rin   [3];
      logic [QB-1:0]    dprev [3];
      logic [SW+1:0]    diff  [3];
      logic [SW-1:0]    sk;
      tun_pkg::ctl_type ck;

      if (k == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               rin[i]   = (SW + 1)'(sq_in[i]);
               dprev[i] = '0;
            end
            sk = s_in;
            ck = ctl_in;
         end
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               rin[i]   = {r_ff[k-1][i], 1'b0};
               dprev[i] = d_ff[k-1][i];
            end
            sk = s_ff[k-1];
            ck = c_ff[k-1];
         end
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            diff[i] = {1'b0, rin[i]} - {2'b00, sk};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            c_ff[k].valid <= 1'b0;
         end else if (en) begin
            c_ff[k].valid <= ck.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            c_ff[k].zero <= ck.zero;
            c_ff[k].neg  <= ck.neg;
            s_ff[k]      <= sk;
            for (int i = 0; i < 3; i++) begin
               r_ff[k][i] <= diff[i][SW+1] ? rin[i][SW-1:0] : diff[i][SW-1:0];
               d_ff[k][i] <= {dprev[i][QB-2:0], ~diff[i][SW+1]};
            end
         end
      end
   end

   assign d_out   = d_ff[QB-1];
   assign ctl_out = c_ff[QB-1];
endmodule

// ===== hdl/tun_root.sv =====
module tun_root #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic [2*FRAC_BITS+2:0]               d_in [3],
   input  tun_pkg::ctl_type                     ctl_in,
   output logic signed [tun_pkg::OUT_WIDTH-1:0] normal [3],
   output logic                                 valid
);
   localparam int KB  = FRAC_BITS + 2;
   localparam int DW  = 2 * KB;
   localparam int RMW = KB + 3;
   localparam int OW2 = (tun_pkg::OUT_WIDTH > KB + 1) ? tun_pkg::OUT_WIDTH : KB + 1;

   logic [DW-1:0]    x_ff    [KB][3];
   logic [RMW-1:0]   rem_ff  [KB][3];
   logic [KB-1:0]    root_ff [KB][3];
   tun_pkg::ctl_type c_ff    [KB];
   logic signed [tun_pkg::OUT_WIDTH-1:0] out_ff [3];
   logic             out_v_ff;

   for (genvar k = 0; k < KB; k++) begin : g_step
      logic [DW-1:0]    xin   [3];
      logic [RMW-1:0]   rprev [3];
      logic [KB-1:0]    qprev [3];
      logic [RMW-1:0]   remin [3];
      logic [RMW:0]     diff  [3];
      tun_pkg::ctl_type ck;

      if (k == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               xin[i]   = {1'b0, d_in[i]};
               rprev[i] = '0;
               qprev[i] = '0;
            end
            ck = ctl_in;
         end
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               xin[i]   = x_ff[k-1][i];
               rprev[i] = rem_ff[k-1][i];
               qprev[i] = root_ff[k-1][i];
            end
            ck = c_ff[k-1];
         end
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            remin[i] = {rprev[i][RMW-3:0], xin[i][DW-1:DW-2]};
            diff[i]  = {1'b0, remin[i]} - (RMW + 1)'({qprev[i], 2'b01});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            c_ff[k].valid <= 1'b0;
         end else if (en) begin
            c_ff[k].valid <= ck.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            c_ff[k].zero <= ck.zero;
            c_ff[k].neg  <= ck.neg;
            for (int i = 0; i < 3; i++) begin
               x_ff[k][i]    <= {xin[i][DW-3:0], 2'b00};
               rem_ff[k][i]  <= diff[i][RMW] ? remin[i] : diff[i][RMW-1:0];
               root_ff[k][i] <= {qprev[i][KB-2:0], ~diff[i][RMW]};
            end
         end
      end
   end

   logic [KB:0]    kp1 [3];
   logic [KB-1:0]  q   [3];
   logic [OW2-1:0] qs  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         kp1[i] = (KB + 1)'(root_ff[KB-1][i]) + (KB + 1)'(1);
         q[i]   = kp1[i][KB:1];
         if (q[i] > (KB'(1) << FRAC_BITS)) begin
            q[i] = KB'(1) << FRAC_BITS;
         end
         qs[i] = c_ff[KB-1].neg[i] ? -OW2'(q[i]) : OW2'(q[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= c_ff[KB-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= c_ff[KB-1].zero ? '0 : qs[i][tun_pkg::OUT_WIDTH-1:0];
         end
      end
   end

   assign normal = out_ff;
   assign valid  = out_v_ff;
endmodule

// ===== hdl/triangle_unit_normal_top.sv =====
// Unit face normal of one triangle per word.
// req_chan carries three vertices a, b, c in signed Q8.8; rsp_chan returns
// normal_x, normal_y, normal_z in signed Q1.14, rounded to nearest, ties
// away from zero. A degenerate triangle gives the zero vector.
// Both channels use valid/ready; a word moves when both are high.
// The pipeline has 7 cross-product stages, one restoring divide stage
// per quotient bit (2*F+3 with F = NORMAL_FRAC_BITS), one square-root
// stage per root bit (F+2) and the output register.
// Throughput: one word per cycle; a new word enters every cycle while the
// output register is empty or being taken.
// When rsp_chan stalls with a word held, the whole pipeline holds and
// req_chan.ready drops; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; in-flight words
// are dropped and the block is ready the cycle after reset.
module triangle_unit_normal_top #(
   parameter int COORD_WIDTH      = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input logic        clock,
   input logic        reset,
   tun_req_if.sink    req_chan,
   tun_rsp_if.source  rsp_chan
);
   localparam int QW = 4 * (COORD_WIDTH + 1);
   localparam int SW = QW + 2;
   localparam int QB = 2 * NORMAL_FRAC_BITS + 3;

   logic                                 en;
   logic signed [COORD_WIDTH-1:0]        a [3];
   logic signed [COORD_WIDTH-1:0]        b [3];
   logic signed [COORD_WIDTH-1:0]        c [3];
   logic [QW-1:0]                        sq [3];
   logic [SW-1:0]                        s;
   logic [QB-1:0]                        d [3];
   tun_pkg::ctl_type                     ctl_cross;
   tun_pkg::ctl_type                     ctl_div;
   logic signed [tun_pkg::OUT_WIDTH-1:0] normal [3];
   logic                                 out_valid;

   assign en = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   assign a[0] = req_chan.a_x;
   assign a[1] = req_chan.a_y;
   assign a[2] = req_chan.a_z;
   assign b[0] = req_chan.b_x;
   assign b[1] = req_chan.b_y;
   assign b[2] = req_chan.b_z;
   assign c[0] = req_chan.c_x;
   assign c[1] = req_chan.c_y;
   assign c[2] = req_chan.c_z;

   tun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_chan.valid),
      .a        (a),
      .b        (b),
      .c        (c),
      .sq_out   (sq),
      .s_out    (s),
      .ctl_out  (ctl_cross)
   );

   tun_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .sq_in   (sq),
      .s_in    (s),
      .ctl_in  (ctl_cross),
      .d_out   (d),
      .ctl_out (ctl_div)
   );

   tun_root #(.FRAC_BITS(NORMAL_FRAC_BITS)) u_root (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .d_in   (d),
      .ctl_in (ctl_div),
      .normal (normal),
      .valid  (out_valid)
   );

   assign rsp_chan.valid    = out_valid;
   assign rsp_chan.normal_x = normal[0];
   assign rsp_chan.normal_y = normal[1];
   assign rsp_chan.normal_z = normal[2];
endmodule

// ===== hdl/tun_chk.sv =====
`include "triangle_unit_normal_top_assert.svh"

module tun_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   `TUN_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp word dropped while stalled")
   `TUN_ASSERT(a_stall_blocks, rsp_valid && !rsp_ready |-> !req_ready, "req taken during rsp stall")
   `TUN_ASSERT(a_empty_ready, !rsp_valid |-> req_ready, "req not ready with empty output")
   `TUN_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "rsp valid right after reset")
endmodule

bind triangle_unit_normal_top tun_chk u_tun_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int FRAC = 14;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
   } normal_word;

   class normal_scoreboard;
      normal_word pending[$];
      int errors = 0;

      function automatic logic [15:0] unit_comp(longint mag, logic [127:0] s);
         logic [127:0] rhs;
         logic [127:0] odd;
         longint q;
         longint t;
         rhs = (128'(mag) * 128'(mag)) << (2 * FRAC + 2);
         q = 0;
         for (int b = FRAC; b >= 0; b--) begin
            t = q | (64'd1 << b);
            if (t <= (64'd1 << FRAC)) begin
               odd = 128'(2 * t - 1);
               if (odd * odd * s <= rhs) q = t;
            end
         end
         return q[15:0];
      endfunction

      function void note_triangle(logic signed [15:0] v[9]);
         longint e1[3];
         longint e2[3];
         longint n[3];
         longint m;
         logic [127:0] s;
         logic [15:0] r[3];
         normal_word w;
         for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(v[i]) - longint'(v[3 + i]);
            e2[i] = longint'(v[3 + i]) - longint'(v[6 + i]);
         end
         n[0] = e1[1] * e2[2] - e1[2] * e2[1];
         n[1] = e1[2] * e2[0] - e1[0] * e2[2];
         n[2] = e1[0] * e2[1] - e1[1] * e2[0];
         s = 0;
         for (int i = 0; i < 3; i++) begin
            m = n[i] < 0 ? -n[i] : n[i];
            s += 128'(m) * 128'(m);
         end
         for (int i = 0; i < 3; i++) begin
            m = n[i] < 0 ? -n[i] : n[i];
            r[i] = (s == 0) ? 16'd0 : unit_comp(m, s);
            if (n[i] < 0) r[i] = -r[i];
         end
         w.nx = r[0];
         w.ny = r[1];
         w.nz = r[2];
         pending.push_back(w);
      endfunction

      function void check_normal(normal_word got);
         normal_word exp_w;
         if (pending.size() == 0) begin
            $display("%0t unexpected word x=%0d y=%0d z=%0d", $time, got.nx, got.ny, got.nz);
            errors++;
            return;
         end
         exp_w = pending.pop_front();
         if (got.nx !== exp_w.nx || got.ny !== exp_w.ny || got.nz !== exp_w.nz) begin
            $display("%0t mismatch expected x=%0d y=%0d z=%0d actual x=%0d y=%0d z=%0d",
                     $time, exp_w.nx, exp_w.ny, exp_w.nz, got.nx, got.ny, got.nz);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int send_idle_pct;
   int recv_idle_pct;
   int cycles;
   normal_scoreboard board;

   tun_req_if #(.COORD_WIDTH(16)) req_chan ();
   tun_rsp_if rsp_chan ();

   triangle_unit_normal_top #(.COORD_WIDTH(16), .NORMAL_FRAC_BITS(FRAC)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      normal_word w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         w.nx = rsp_chan.normal_x;
         w.ny = rsp_chan.normal_y;
         w.nz = rsp_chan.normal_z;
         board.check_normal(w);
      end
      if (!reset && req_chan.valid && req_chan.ready)
         board.note_triangle('{req_chan.a_x, req_chan.a_y, req_chan.a_z,
                               req_chan.b_x, req_chan.b_y, req_chan.b_z,
                               req_chan.c_x, req_chan.c_y, req_chan.c_z});
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_triangle(logic signed [15:0] v[9]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      {req_chan.a_x, req_chan.a_y, req_chan.a_z} <= {v[0], v[1], v[2]};
      {req_chan.b_x, req_chan.b_y, req_chan.b_z} <= {v[3], v[4], v[5]};
      {req_chan.c_x, req_chan.c_y, req_chan.c_z} <= {v[6], v[7], v[8]};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      logic signed [15:0] v[9];
      int span;
      for (int k = 0; k < count; k++) begin
         span = $urandom_range(3);
         for (int i = 0; i < 9; i++) begin
            case (span)
               0: v[i] = 16'($signed($urandom_range(15)) - 8);
               1: v[i] = 16'($signed($urandom_range(1023)) - 512);
               default: v[i] = 16'($urandom);
            endcase
         end
         if ($urandom_range(19) == 0) begin
            v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
         end
         send_triangle(v);
      end
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic signed [15:0] mx;
      logic signed [15:0] mn;
      board = new();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      {req_chan.a_x, req_chan.a_y, req_chan.a_z} = '0;
      {req_chan.b_x, req_chan.b_y, req_chan.b_z} = '0;
      {req_chan.c_x, req_chan.c_y, req_chan.c_z} = '0;
      rsp_chan.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      mx = 16'sh7fff;
      mn = -16'sh8000;
      send_triangle('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_triangle('{1, 2, 3, 1, 2, 3, 5, -7, 9});
      send_triangle('{2, 4, 6, 1, 2, 3, 0, 0, 0});
      send_triangle('{256, 0, 0, 0, 0, 0, 0, 256, 0});
      send_triangle('{0, 256, 0, 0, 0, 0, 0, 0, 256});
      send_triangle('{0, 0, 256, 0, 0, 0, 256, 0, 0});
      send_triangle('{0, 256, 0, 0, 0, 0, 256, 0, 0});
      send_triangle('{1, 0, 0, 0, 0, 0, 0, 1, 0});
      send_triangle('{1, 0, 0, 0, 0, 0, 1, 1, 1});
      send_triangle('{1, 2, 0, 0, 0, 0, 2, 1, 0});
      send_triangle('{mx, mx, mx, mn, mn, mn, mx, mn, mx});
      send_triangle('{mn, mx, mn, mx, mn, mx, mn, mn, mx});
      send_triangle('{mx, 0, 0, mn, 0, 0, mn, mx, 0});
      send_triangle('{mn, mn, mn, mx, mx, mx, mn, mx, mn});
      send_triangle('{-1, -1, -1, 0, 0, 0, 1, -1, 1});
      send_triangle('{mx, mx, 0, mn, 0, mn, 0, mn, mx});
      send_triangle('{-21846, 21845, -1, 21845, -21846, 0, 1, 7, -3});
      drain();
      send_idle_pct = 28;
      recv_idle_pct = 67;
      send_random(300);
      drain();
      send_idle_pct = 67;
      recv_idle_pct = 28;
      send_random(300);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(300);
      drain();
      repeat (3 * FRAC + 30) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
